// File: hw/rtl/pfc_pkg.sv
// shared types, format codes and the byte-to-float table for the pixel format converter
package pfc_pkg;

  typedef enum logic [2:0] {
    FMT_R_U8     = 3'd0,
    FMT_RGB_U8   = 3'd1,
    FMT_BGR_U8   = 3'd2,
    FMT_RGBA_U8  = 3'd3,
    FMT_BGRA_U8  = 3'd4,
    FMT_FLOAT4   = 3'd5
  } fmt_t;

  localparam logic REG_SRC_FMT = 1'b0;
  localparam logic REG_TGT_FMT = 1'b1;

  localparam logic [31:0] FLOAT_ONE = 32'h3f80_0000;
  localparam logic [7:0]  BYTE_MAX  = 8'hff;

  typedef struct packed {
    logic src_float;
    logic tgt_float;
  } mode_t;

  typedef logic [31:0] exp_tbl_t [256];

  // nearest single to v/255, round to nearest even
  function automatic exp_tbl_t gen_exp_tbl();
    exp_tbl_t t;
    longint   m;
    longint   r;
    int       s;
    for (int v = 0; v < 256; v++) begin
      if (v == 0) begin
        t[v] = 32'h0;
      end else if (v == 255) begin
        t[v] = FLOAT_ONE;
      end else begin
        s = 0;
        while ((v << s) < 255) s++;
        m = (longint'(v) << (23 + s)) / 255;
        r = (longint'(v) << (23 + s)) % 255;
        if (2 * r > 255) m++;
        if (m == (longint'(1) << 24)) begin
          m = longint'(1) << 23;
          s--;
        end
        t[v] = {1'b0, 8'(127 - s), m[22:0]};
      end
    end
    return t;
  endfunction

  localparam exp_tbl_t EXP_TBL = gen_exp_tbl();

endpackage

// File: hw/rtl/pfc_lane.sv
// one conversion lane: byte to float, float to byte, or pass; the table lookup or product is registered
module pfc_lane (
  input  logic              clk,
  input  logic              en,
  input  pfc_pkg::mode_t    mode,
  input  logic [31:0]       din,
  output logic [31:0]       dout
);

  logic        quant_r;
  logic [31:0] val_r;
  logic [31:0] prod_r;
  logic [7:0]  exp_r;
  logic        sat_r;
  logic        zero_r;

  logic        quant_nxt;
  logic [31:0] val_nxt;
  logic [31:0] prod_nxt;
  logic        sat_nxt;
  logic        zero_nxt;
  logic        nan;
  logic [23:0] mant;

  always_comb begin
    nan       = (din[30:23] == 8'hff) && (din[22:0] != 23'h0);
    mant      = {din[30:23] != 8'h0, din[22:0]};
    prod_nxt  = 32'(mant) * 32'd255;
    sat_nxt   = !din[31] && (din[30:23] >= 8'd127) && !nan;
    zero_nxt  = din[31] || nan || (din[30:23] == 8'h0);
    quant_nxt = mode.src_float && !mode.tgt_float;
    case ({mode.src_float, mode.tgt_float})
      2'b01:   val_nxt = pfc_pkg::EXP_TBL[din[7:0]];
      2'b00:   val_nxt = {24'h0, din[7:0]};
      default: val_nxt = din;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      quant_r <= quant_nxt;
      val_r   <= val_nxt;
      prod_r  <= prod_nxt;
      exp_r   <= din[30:23];
      sat_r   <= sat_nxt;
      zero_r  <= zero_nxt;
    end
  end

  // round the product to 24 significant bits, then truncate to an integer
  logic [24:0] rnd;
  logic        up;
  logic [32:0] prnd;
  logic [8:0]  sh;
  logic [32:0] ival;
  logic [7:0]  qbyte;

  always_comb begin
    if (prod_r[31]) begin
      up   = prod_r[7] && ((prod_r[6:0] != 7'h0) || prod_r[8]);
      rnd  = {1'b0, prod_r[31:8]} + 25'(up);
      prnd = {rnd, 8'h0};
    end else begin
      up   = prod_r[6] && ((prod_r[5:0] != 6'h0) || prod_r[7]);
      rnd  = {1'b0, prod_r[30:7]} + 25'(up);
      prnd = {1'b0, rnd, 7'h0};
    end
    sh   = 9'd150 - {1'b0, exp_r};
    ival = prnd >> sh[5:0];
    if (sat_r) begin
      qbyte = pfc_pkg::BYTE_MAX;
    end else if (zero_r || (sh > 9'd32)) begin
      qbyte = 8'h0;
    end else if (ival >= 33'd255) begin
      qbyte = pfc_pkg::BYTE_MAX;
    end else begin
      qbyte = ival[7:0];
    end
    dout = quant_r ? {24'h0, qbyte} : val_r;
  end

endmodule

// File: hw/rtl/pfc_merge.sv
// merges the lane results into the target channel order and holds the output
module pfc_merge (
  input  logic              clk,
  input  logic              en,
  input  logic [3:0][31:0]  lane,
  input  logic [2:0]        tgt_fmt,
  input  logic              bad,
  input  logic              last,
  output logic [3:0][31:0]  chan,
  output logic              chan_last
);

  logic [3:0][31:0] chan_r;
  logic [3:0][31:0] chan_nxt;
  logic             last_r;

  always_comb begin
    chan_nxt = '0;
    if (!bad) begin
      case (tgt_fmt)
        pfc_pkg::FMT_R_U8: begin
          chan_nxt[0] = lane[0];
        end
        pfc_pkg::FMT_RGB_U8: begin
          chan_nxt[0] = lane[0];
          chan_nxt[1] = lane[1];
          chan_nxt[2] = lane[2];
        end
        pfc_pkg::FMT_BGR_U8: begin
          chan_nxt[0] = lane[2];
          chan_nxt[1] = lane[1];
          chan_nxt[2] = lane[0];
        end
        pfc_pkg::FMT_BGRA_U8: begin
          chan_nxt[0] = lane[2];
          chan_nxt[1] = lane[1];
          chan_nxt[2] = lane[0];
          chan_nxt[3] = lane[3];
        end
        default: begin
          chan_nxt = lane;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      chan_r <= chan_nxt;
      last_r <= last;
    end
  end

  assign chan      = chan_r;
  assign chan_last = last_r;

endmodule

// File: hw/rtl/pixel_format_converter.sv
// Converts one pixel per transfer between R_U8, RGB_U8, BGR_U8, RGBA_U8, BGRA_U8 and
// four-channel single-precision float layouts. A pixel passes the lane register, which
// holds the per-lane product or table lookup, and then the merge register, which holds
// the merged output. One pixel is accepted every cycle while the output side keeps up;
// four lanes work on red, green, blue and alpha at once. Formats are set through the cfg
// port while idle; the block itself does not enforce this, it is for the user to keep.
module pixel_format_converter (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic         cfg_addr,
  input  logic [2:0]   cfg_wdata,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [127:0] in_tdata,   // in_chan0, in_chan1, in_chan2, in_chan3
  input  logic         in_tlast,
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [127:0] out_tdata,  // out_chan0, out_chan1, out_chan2, out_chan3
  output logic         out_tlast
);

  logic [2:0] src_fmt_r;
  logic [2:0] tgt_fmt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_fmt_r <= pfc_pkg::FMT_R_U8;
      tgt_fmt_r <= pfc_pkg::FMT_R_U8;
    end else if (cfg_we) begin
      case (cfg_addr)
        pfc_pkg::REG_SRC_FMT: src_fmt_r <= cfg_wdata;
        pfc_pkg::REG_TGT_FMT: tgt_fmt_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // pipeline control
  logic s1_v_r;
  logic s2_v_r;
  logic s2_ready;
  logic s1_ready;
  logic in_xfer;

  assign s2_ready  = !s2_v_r || out_tready;
  assign s1_ready  = !s1_v_r || s2_ready;
  assign in_tready = s1_ready;
  assign in_xfer   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      if (s1_ready) s1_v_r <= in_tvalid;
      if (s2_ready) s2_v_r <= s1_v_r;
    end
  end

  // decode to canonical red, green, blue, alpha
  logic [3:0][31:0] c;
  logic [3:0][31:0] canon;
  logic [3:0][31:0] lane_out;
  pfc_pkg::mode_t   mode;
  logic             bad;

  always_comb begin
    c              = in_tdata;
    bad            = (src_fmt_r > pfc_pkg::FMT_FLOAT4) || (tgt_fmt_r > pfc_pkg::FMT_FLOAT4);
    mode.src_float = (src_fmt_r == pfc_pkg::FMT_FLOAT4);
    mode.tgt_float = (tgt_fmt_r == pfc_pkg::FMT_FLOAT4);
    canon          = c;
    if (!mode.src_float) begin
      canon[3] = {24'h0, pfc_pkg::BYTE_MAX};
      case (src_fmt_r)
        pfc_pkg::FMT_R_U8: begin
          canon[0] = c[0];
          canon[1] = c[0];
          canon[2] = c[0];
        end
        pfc_pkg::FMT_RGB_U8: begin
          canon[0] = c[0];
          canon[1] = c[1];
          canon[2] = c[2];
        end
        pfc_pkg::FMT_BGR_U8: begin
          canon[0] = c[2];
          canon[1] = c[1];
          canon[2] = c[0];
        end
        pfc_pkg::FMT_RGBA_U8: begin
          canon[0] = c[0];
          canon[1] = c[1];
          canon[2] = c[2];
          canon[3] = c[3];
        end
        default: begin
          canon[0] = c[2];
          canon[1] = c[1];
          canon[2] = c[0];
          canon[3] = c[3];
        end
      endcase
    end
  end

  logic [2:0] s1_tgt_r;
  logic       s1_bad_r;
  logic       s1_last_r;

  always_ff @(posedge clk) begin
    if (s1_ready) begin
      s1_tgt_r  <= tgt_fmt_r;
      s1_bad_r  <= bad;
      s1_last_r <= in_tlast;
    end
  end

  for (genvar g = 0; g < 4; g++) begin : g_lane
    pfc_lane u_lane (
      .clk  (clk),
      .en   (s1_ready),
      .mode (mode),
      .din  (canon[g]),
      .dout (lane_out[g])
    );
  end

  logic [3:0][31:0] out_chan;

  pfc_merge u_merge (
    .clk       (clk),
    .en        (s2_ready),
    .lane      (lane_out),
    .tgt_fmt   (s1_tgt_r),
    .bad       (s1_bad_r),
    .last      (s1_last_r),
    .chan      (out_chan),
    .chan_last (out_tlast)
  );

  assign out_tvalid = s2_v_r;
  assign out_tdata  = out_chan;

  a_in_fill : assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> s1_v_r)
    else $error("accepted transfer did not reach first stage");

  a_stall : assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && s2_v_r && !out_tready) |-> !in_tready)
    else $error("input accepted while pipeline full and stalled");

  a_advance : assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && s2_ready) |=> out_tvalid)
    else $error("first stage item lost on its way to output");

endmodule
